/* rtl/ple_pkg.sv */
`default_nettype none
package ple_pkg;

  localparam int REQ_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_DEL_TAIL = 3'd4,
    REQ_DEL_POS  = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic             accept;
    status_t          status;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             emit;
    logic             emit_marker;
    logic             emit_last;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_value;
  } ple_cmd_t;

endpackage
`default_nettype wire

/* rtl/ple_if.sv */
`default_nettype none
interface ple_in_if;
  import ple_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    list_empty;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] element_value;
  logic                    last;

  modport source (output valid, status, list_empty, element_index, element_value, last,
                  input ready);
  modport sink   (input valid, status, list_empty, element_index, element_value, last,
                  output ready);
endinterface
`default_nettype wire

/* rtl/ple_ctrl.sv */
`default_nettype none
module ple_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ple_pkg::REQ_W-1:0]    req_type,
  input  logic [ple_pkg::POS_W-1:0]    position,
  input  logic                         emit_ok,
  output ple_pkg::ple_cmd_t            cmd
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PLACE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] stop_r, stop_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] e_r, e_nxt;
  logic          ins_r, ins_nxt;
  logic          wb_v_r, wb_v_nxt;
  logic [AW-1:0] wb_addr_r, wb_addr_nxt;

  logic [PW-1:0] cnt_w, pos_w, idx_w;
  logic [AW-1:0] cnt_m1;
  logic          is_ins, is_del, pos_bad, do_ins, do_del;
  status_t       st;

  // request decode
  always_comb begin
    cnt_w   = PW'(count_r);
    pos_w   = PW'(position);
    cnt_m1  = AW'(count_r - CW'(1));
    idx_w   = '0;
    is_ins  = 1'b0;
    is_del  = 1'b0;
    pos_bad = 1'b0;
    st      = ST_OK;
    unique case (req_type)
      REQ_INS_HEAD: begin
        is_ins = 1'b1;
      end
      REQ_INS_TAIL: begin
        is_ins = 1'b1;
        idx_w  = cnt_w;
      end
      REQ_INS_POS: begin
        is_ins  = 1'b1;
        idx_w   = pos_w - PW'(1);
        pos_bad = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
      end
      REQ_DEL_HEAD: begin
        is_del = 1'b1;
      end
      REQ_DEL_TAIL: begin
        is_del = 1'b1;
        idx_w  = cnt_w - PW'(1);
      end
      REQ_DEL_POS: begin
        is_del  = 1'b1;
        idx_w   = pos_w - PW'(1);
        pos_bad = (pos_w == '0) || (pos_w > cnt_w);
      end
      default: st = ST_INVALID;
    endcase
    if (is_ins) begin
      if (count_r == CW'(CAPACITY)) st = ST_OVERFLOW;
      else if (pos_bad)             st = ST_INVALID;
    end
    if (is_del) begin
      if (count_r == '0) st = ST_UNDERFLOW;
      else if (pos_bad)  st = ST_INVALID;
    end
    do_ins = is_ins && (st == ST_OK);
    do_del = is_del && (st == ST_OK);
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    j_nxt       = j_r;
    stop_nxt    = stop_r;
    idx_nxt     = idx_r;
    e_nxt       = e_r;
    ins_nxt     = ins_r;
    wb_v_nxt    = 1'b0;
    wb_addr_nxt = wb_addr_r;
    in_ready    = 1'b0;
    cmd         = '0;
    // write-back of a moved entry, in the cycle after its read
    cmd.wr_en   = wb_v_r;
    cmd.wr_addr = IDX_W'(wb_addr_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = emit_ok;
        if (in_valid && emit_ok) begin
          cmd.accept = 1'b1;
          cmd.status = st;
          e_nxt      = '0;
          idx_nxt    = idx_w[AW-1:0];
          state_nxt  = S_EMIT;
          if (do_ins) begin
            count_nxt = count_r + CW'(1);
            ins_nxt   = 1'b1;
            if (idx_w < cnt_w) begin
              j_nxt     = cnt_m1;
              stop_nxt  = idx_w[AW-1:0];
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_PLACE;
            end
          end else if (do_del) begin
            count_nxt = count_r - CW'(1);
            ins_nxt   = 1'b0;
            if (idx_w + PW'(1) < cnt_w) begin
              j_nxt     = AW'(idx_w + PW'(1));
              stop_nxt  = cnt_m1;
              state_nxt = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = IDX_W'(j_r);
        wb_v_nxt    = 1'b1;
        wb_addr_nxt = ins_r ? j_r + AW'(1) : j_r - AW'(1);
        if (j_r == stop_r) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = ins_r ? j_r - AW'(1) : j_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = ins_r ? S_PLACE : S_EMIT;
      end
      S_PLACE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_addr  = IDX_W'(idx_r);
        cmd.wr_value = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd.emit = 1'b1;
          if (count_r == '0) begin
            cmd.emit_marker = 1'b1;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = IDX_W'(e_r);
            cmd.emit_last = (e_r == cnt_m1);
            if (e_r == cnt_m1) state_nxt = S_IDLE;
            else               e_nxt     = e_r + AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wb_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wb_v_r  <= wb_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    stop_r    <= stop_nxt;
    idx_r     <= idx_nxt;
    e_r       <= e_nxt;
    ins_r     <= ins_nxt;
    wb_addr_r <= wb_addr_nxt;
  end

endmodule
`default_nettype wire

/* rtl/ple_dp.sv */
`default_nettype none
module ple_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ple_pkg::ple_cmd_t                cmd,
  input  logic signed [ple_pkg::VAL_W-1:0] in_value,
  output logic                             emit_ok,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ple_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_list_empty,
  output logic [ple_pkg::IDX_W-1:0]        out_element_index,
  output logic signed [ple_pkg::VAL_W-1:0] out_element_value,
  output logic                             out_last
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] value_r;
  status_t          status_r;

  logic             pend_v_r, pend_v_nxt;
  logic             pend_marker_r;
  logic             pend_last_r;
  logic [IDX_W-1:0] pend_idx_r;

  logic             o_valid_r;
  status_t          o_status_r;
  logic             o_empty_r;
  logic [IDX_W-1:0] o_idx_r;
  logic [VAL_W-1:0] o_value_r;
  logic             o_last_r;
  logic             o_free;

  assign o_free  = !o_valid_r || out_ready;
  assign emit_ok = !pend_v_r || o_free;

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (o_free)   pend_v_nxt = 1'b0;
    if (cmd.emit) pend_v_nxt = 1'b1;
  end

  // list storage, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_value ? value_r : rd_data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r  <= in_value;
      status_r <= cmd.status;
    end
    if (cmd.emit) begin
      pend_marker_r <= cmd.emit_marker;
      pend_last_r   <= cmd.emit_last;
      pend_idx_r    <= cmd.rd_addr;
    end
    if (o_free && pend_v_r) begin
      o_status_r <= status_r;
      o_empty_r  <= pend_marker_r;
      o_idx_r    <= pend_marker_r ? '0 : pend_idx_r;
      o_value_r  <= pend_marker_r ? '0 : rd_data_r;
      o_last_r   <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      if (o_free) o_valid_r <= pend_v_r;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_status        = o_status_r;
  assign out_list_empty    = o_empty_r;
  assign out_element_index = o_idx_r;
  assign out_element_value = o_value_r;
  assign out_last          = o_last_r;

endmodule
`default_nettype wire

/* rtl/positional_list_engine.sv */
// channel   dir  handshake      payload
// in_if     in   valid/ready    req_type, value, position
// out_if    out  valid/ready    status, list_empty, element_index, element_value, last
//
// a request shifts the moved elements through the list memory, places the value of an
// insert, then lists every element (or the empty marker) read from the list memory
// reset clears the element count and the handshake state; the memory is not cleared
// out_ready low holds the output register and pauses the listing; a new request is taken
// once the previous listing has been fully issued
`default_nettype none
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst_n,
  ple_in_if.sink    in_if,
  ple_out_if.source out_if
);
  import ple_pkg::*;

  ple_cmd_t cmd;
  logic     emit_ok;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .req_type (in_if.req_type),
    .position (in_if.position),
    .emit_ok  (emit_ok),
    .cmd      (cmd)
  );

  ple_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_value          (in_if.value),
    .emit_ok           (emit_ok),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_status        (out_if.status),
    .out_list_empty    (out_if.list_empty),
    .out_element_index (out_if.element_index),
    .out_element_value (out_if.element_value),
    .out_last          (out_if.last)
  );

endmodule
`default_nettype wire

/* rtl/ple_checker.sv */
`default_nettype none
module ple_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ple_pkg::STATUS_W-1:0]     out_status,
  input logic                             out_list_empty,
  input logic [ple_pkg::IDX_W-1:0]        out_element_index,
  input logic signed [ple_pkg::VAL_W-1:0] out_element_value,
  input logic                             out_last
);
  import ple_pkg::*;

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element_value)
      && $stable(out_element_index) && $stable(out_last))
    else $error("stalled result changed");

  // empty marker is a single zeroed transaction
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_empty |-> out_last && (out_element_index == '0)
      && (out_element_value == '0))
    else $error("malformed empty marker");

  // overflow happens on a full list, so it never comes with the empty marker
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OVERFLOW) |-> !out_list_empty)
    else $error("overflow reported on empty list");

  // underflow leaves the list empty
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDERFLOW) |-> out_list_empty)
    else $error("underflow reported on non-empty list");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("second request taken back to back");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_status        (out_if.status),
  .out_list_empty    (out_if.list_empty),
  .out_element_index (out_if.element_index),
  .out_element_value (out_if.element_value),
  .out_last          (out_if.last)
);
`default_nettype wire
